[design/obpa_pkg.sv]
// ----------------------------------------------------------------------------
// obpa_pkg
// Shared types, constants and the log2 table for the band power aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package obpa_pkg;

	localparam int MAX_BANDS = 64;
	localparam int BAND_W    = 6;
	localparam int CNT_W     = 7;
	localparam int BIN_W     = 12;
	localparam int EDGE_W    = 13;
	localparam int WIDTH_W   = 16;
	localparam int PW_W      = 32;
	localparam int SUM_W     = 44;
	localparam int HITS_W    = 13;
	localparam int LVL_W     = 16;
	localparam int PROD_W    = 60;
	localparam int LOG_W     = 22;
	localparam int DBP_W     = 44;

	localparam logic signed [LVL_W-1:0] MIN_LEVEL = -16'sd16000;
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
	// 197282/65536 dB per log2 step, times 16 for Q4
	localparam logic [LOG_W-1:0]  DB_SCALE = 22'd3156512;
	// offset for a Q8 argument: 8 * 65536 * DB_SCALE
	localparam logic [DBP_W-1:0]  DB_OFS_Q8 = DBP_W'(DB_SCALE) << 19;

	localparam logic CFG_BAND_COUNT = 1'b0;
	localparam logic CFG_FLOOR      = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BIN  = 2'd1,
		CMD_END  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [BAND_W-1:0]  band_number;
		logic [EDGE_W-1:0]  edge_bin;
		logic [WIDTH_W-1:0] width_bins;
		logic [BIN_W-1:0]   bin_index;
		logic [PW_W-1:0]    power;
		logic               peak_reset;
	} in_item_t;

	typedef struct packed {
		logic [BAND_W-1:0]        band_out;
		logic signed [LVL_W-1:0]  level;
		logic signed [LVL_W-1:0]  peak_level;
		logic [BAND_W-1:0]        loudest_band;
		logic                     last;
	} out_item_t;

	typedef enum logic [2:0] {
		IX_HOLD,
		IX_ZERO,
		IX_INC,
		IX_DEC,
		IX_TOP
	} idx_op_t;

	typedef enum logic [2:0] {
		LS_RD,
		LS_FLOOR,
		LS_LVL,
		LS_MIN,
		LS_IP
	} lvl_src_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_CHK,
		ST_B0,
		ST_B0_W,
		ST_P1_RD,
		ST_P1_EVAL,
		ST_P1_MUL,
		ST_P1_DIVS,
		ST_P1_DIVW,
		ST_P1_LVLW,
		ST_P2_INIT,
		ST_P2_RD,
		ST_P2_EVAL,
		ST_P2_M2,
		ST_P2_ABS,
		ST_P2_DIVS,
		ST_P2_DIVW,
		ST_OUT_RD,
		ST_OUT_EVAL
	} st_t;

	typedef enum logic [2:0] {
		LV_IDLE,
		LV_NORM,
		LV_TAB,
		LV_MUL,
		LV_DIFF,
		LV_RND
	} lv_st_t;

	typedef struct packed {
		logic     capture;
		logic     tbl_wr;
		logic     use_ptr;
		logic     ptr_inc;
		logic     acc_wr;
		logic     frame_clr;
		idx_op_t  idx_op;
		lvl_src_t lvl_src;
		logic     lvl_wr;
		logic     prev_wr;
		logic     t1_clr;
		logic     t1_upd;
		logic     t2_init;
		logic     t2_upd;
		logic     loud_upd;
		logic     mul_lo;
		logic     mul_hi;
		logic     div_start;
		logic     div_sel;
		logic     lvl_start;
		logic     lvl_fb;
		logic     ip_m1;
		logic     ip_m2;
		logic     ip_abs;
		logic     out_load;
	} ctl_t;

	typedef struct packed {
		logic ptr_lt_cnt;
		logic ptr_ge1;
		logic bin_ge_edge;
		logic pw_zero;
		logic idx_lt_cnt;
		logic idx_zero;
		logic hits_zero;
		logic quo_zero;
		logic ip_none;
		logic div_done;
		logic lvl_done;
		logic out_busy;
	} sts_t;

	// log2(1 + k/16) in Q16
	function automatic logic [16:0] log_tab(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:    v = 17'd0;
			5'd1:    v = 17'd5732;
			5'd2:    v = 17'd11136;
			5'd3:    v = 17'd16248;
			5'd4:    v = 17'd21098;
			5'd5:    v = 17'd25711;
			5'd6:    v = 17'd30109;
			5'd7:    v = 17'd34312;
			5'd8:    v = 17'd38336;
			5'd9:    v = 17'd42196;
			5'd10:   v = 17'd45904;
			5'd11:   v = 17'd49472;
			5'd12:   v = 17'd52911;
			5'd13:   v = 17'd56229;
			5'd14:   v = 17'd59434;
			5'd15:   v = 17'd62534;
			5'd16:   v = 17'd65536;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[design/obpa_div.sv]
// ----------------------------------------------------------------------------
// obpa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obpa_div import obpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [HITS_W-1:0] den,
	output logic              done,
	output logic [PROD_W-1:0] quo
);

	logic [PROD_W-1:0] acc_q;
	logic [HITS_W-1:0] rem_q;
	logic [HITS_W-1:0] den_q;
	logic [5:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [HITS_W:0]   trial;
	logic              ge;
	logic [HITS_W:0]   diff;

	assign trial = {rem_q, acc_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 6'(PROD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - 6'd1;
				if (step_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[HITS_W-1:0] : trial[HITS_W-1:0];
			acc_q <= {acc_q[PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = acc_q;

endmodule

`default_nettype wire

[design/obpa_lvl.sv]
// ----------------------------------------------------------------------------
// obpa_lvl
// Power to Q11.4 dB: leading-one search, table log2, scale and round.
// ----------------------------------------------------------------------------
`default_nettype none

module obpa_lvl import obpa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [PROD_W-1:0]       x,
	input  logic                    fb,
	output logic                    done,
	output logic signed [LVL_W-1:0] level
);

	lv_st_t state_q, state_d;

	logic [PROD_W-1:0]       norm_q;
	logic [5:0]              e_q;
	logic                    fb_q;
	logic [LOG_W-1:0]        lg_q;
	logic [DBP_W-1:0]        a_q;
	logic [DBP_W-1:0]        mag_q;
	logic                    neg_q;
	logic signed [LVL_W-1:0] level_q;
	logic                    done_q;

	logic [3:0]        k;
	logic [11:0]       r;
	logic [16:0]       t0;
	logic [16:0]       t1;
	logic [24:0]       slope;
	logic [25:0]       frac;
	logic [DBP_W-1:0]  ofs;
	logic [DBP_W-1:0]  rnd;
	logic [15:0]       mag16;

	assign k     = norm_q[PROD_W-2 -: 4];
	assign r     = norm_q[PROD_W-6 -: 12];
	assign t0    = log_tab({1'b0, k});
	assign t1    = log_tab({1'b0, k} + 5'd1);
	assign slope = 13'(t1 - t0) * r;
	assign frac  = (26'(slope) + 26'd2048) >> 12;
	assign ofs   = fb_q ? DB_OFS_Q8 : '0;
	assign rnd   = mag_q + (DBP_W'(1) << 31);
	assign mag16 = {4'b0, rnd[DBP_W-1:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == LV_RND;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LV_IDLE: if (start) state_d = LV_NORM;
			LV_NORM: if (norm_q[PROD_W-1] || e_q == '0) state_d = LV_TAB;
			LV_TAB:  state_d = LV_MUL;
			LV_MUL:  state_d = LV_DIFF;
			LV_DIFF: state_d = LV_RND;
			LV_RND:  state_d = LV_IDLE;
			default: state_d = LV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LV_IDLE: begin
				norm_q <= x;
				e_q    <= 6'(PROD_W - 1);
				fb_q   <= fb;
			end
			LV_NORM: begin
				// shift until the leading one reaches the top
				if (!norm_q[PROD_W-1] && e_q != '0) begin
					norm_q <= {norm_q[PROD_W-2:0], 1'b0};
					e_q    <= e_q - 6'd1;
				end
			end
			LV_TAB:  lg_q <= {e_q, 16'b0} + LOG_W'(t0) + LOG_W'(frac);
			LV_MUL:  a_q  <= DBP_W'(lg_q) * DBP_W'(DB_SCALE);
			LV_DIFF: begin
				neg_q <= a_q < ofs;
				mag_q <= (a_q < ofs) ? ofs - a_q : a_q - ofs;
			end
			LV_RND:  level_q <= neg_q ? -$signed(mag16) : $signed(mag16);
			default: ;
		endcase
	end

	assign done  = done_q;
	assign level = level_q;

endmodule

`default_nettype wire

[design/obpa_dp.sv]
// ----------------------------------------------------------------------------
// obpa_dp
// Datapath: band tables, accumulators, level and peak stores, interpolation
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module obpa_dp import obpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_data,
	input  logic        out_stall,
	output logic        out_valid,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  ctl_t        ctl,
	output sts_t        sts
);

	// configuration
	logic [CNT_W-1:0]        band_count_q;
	logic signed [LVL_W-1:0] floor_q;
	logic [CNT_W-1:0]        cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= 7'd31;
			floor_q      <= -16'sd1600;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FLOOR) floor_q <= $signed(cfg_data);
			else band_count_q <= cfg_data[CNT_W-1:0];
		end
	end

	always_comb begin
		if (band_count_q == '0) cnt = CNT_W'(1);
		else if (band_count_q > CNT_W'(MAX_BANDS)) cnt = CNT_W'(MAX_BANDS);
		else cnt = band_count_q;
	end

	// captured item
	logic [BIN_W-1:0] bin_q;
	logic [PW_W-1:0]  pw_q;
	logic             pkr_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			bin_q <= in_data.bin_index;
			pw_q  <= in_data.power;
			pkr_q <= in_data.peak_reset;
		end
	end

	// pointers
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctl.frame_clr) ptr_q <= '0;
			else if (ctl.ptr_inc) ptr_q <= ptr_q + CNT_W'(1);
			case (ctl.idx_op)
				IX_ZERO: idx_q <= '0;
				IX_INC:  idx_q <= idx_q + CNT_W'(1);
				IX_DEC:  idx_q <= idx_q - CNT_W'(1);
				IX_TOP:  idx_q <= cnt - CNT_W'(1);
				default: ;
			endcase
		end
	end

	logic [BAND_W-1:0] rd_addr;
	logic [BAND_W-1:0] ptr_a;
	logic [BAND_W-1:0] idx_a;

	assign ptr_a   = ptr_q[BAND_W-1:0];
	assign idx_a   = idx_q[BAND_W-1:0];
	assign rd_addr = ctl.use_ptr ? ptr_a : idx_a;

	// memories
	logic [EDGE_W-1:0]  edge_mem  [MAX_BANDS];
	logic [WIDTH_W-1:0] width_mem [MAX_BANDS];
	logic [SUM_W-1:0]   sum_mem   [MAX_BANDS];
	logic [HITS_W-1:0]  hits_mem  [MAX_BANDS];
	logic [LVL_W-1:0]   level_mem [MAX_BANDS];
	logic [LVL_W-1:0]   peak_mem  [MAX_BANDS];
	logic [BAND_W+LVL_W-1:0] prev_mem [MAX_BANDS];

	logic [MAX_BANDS-1:0] acc_vld_q;
	logic [MAX_BANDS-1:0] peak_vld_q;

	logic [EDGE_W-1:0]       edge_rd;
	logic [WIDTH_W-1:0]      width_rd;
	logic [SUM_W-1:0]        sum_raw;
	logic [HITS_W-1:0]       hits_raw;
	logic signed [LVL_W-1:0] level_rd;
	logic [LVL_W-1:0]        peak_raw;
	logic [BAND_W+LVL_W-1:0] prev_rd;
	logic                    acc_vld_rd;
	logic                    peak_vld_rd;

	logic [SUM_W-1:0]        sum_cur;
	logic [HITS_W-1:0]       hits_cur;
	logic signed [LVL_W-1:0] peak_cur;
	logic signed [LVL_W-1:0] cur_level;
	logic signed [LVL_W-1:0] new_peak;
	logic [SUM_W:0]          sum_add;

	// nearest filled band below, kept for the interpolation pass
	logic [BAND_W-1:0]       t1_q;
	logic signed [LVL_W-1:0] l1_q;

	assign sum_cur  = acc_vld_rd ? sum_raw : '0;
	assign hits_cur = acc_vld_rd ? hits_raw : '0;
	assign peak_cur = peak_vld_rd ? $signed(peak_raw) : MIN_LEVEL;
	assign new_peak = (level_rd > peak_cur || pkr_q) ? level_rd : peak_cur;
	assign sum_add  = {1'b0, sum_cur} + (SUM_W+1)'(pw_q);

	always_ff @(posedge clk) begin
		edge_rd  <= edge_mem[rd_addr];
		width_rd <= width_mem[rd_addr];
		sum_raw  <= sum_mem[rd_addr];
		hits_raw <= hits_mem[rd_addr];
		level_rd <= $signed(level_mem[rd_addr]);
		peak_raw <= peak_mem[rd_addr];
		prev_rd  <= prev_mem[rd_addr];
		if (ctl.tbl_wr) begin
			edge_mem[in_data.band_number]  <= in_data.edge_bin;
			width_mem[in_data.band_number] <= in_data.width_bins;
		end
		if (ctl.acc_wr) begin
			sum_mem[ptr_a]  <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
			hits_mem[ptr_a] <= (hits_cur == HITS_MAX) ? HITS_MAX : hits_cur + HITS_W'(1);
		end
		if (ctl.lvl_wr) level_mem[idx_a] <= cur_level;
		if (ctl.prev_wr) prev_mem[idx_a] <= {t1_q, l1_q};
		if (ctl.out_load) peak_mem[idx_a] <= new_peak;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q   <= '0;
			peak_vld_q  <= '0;
			acc_vld_rd  <= 1'b0;
			peak_vld_rd <= 1'b0;
		end else begin
			acc_vld_rd  <= acc_vld_q[rd_addr];
			peak_vld_rd <= peak_vld_q[rd_addr];
			if (ctl.frame_clr) acc_vld_q <= '0;
			else if (ctl.acc_wr) acc_vld_q[ptr_a] <= 1'b1;
			if (ctl.out_load) peak_vld_q[idx_a] <= 1'b1;
		end
	end

	// band value: sum * width in two halves, then divide by hits
	logic [37:0]       plo_q;
	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_lo) plo_q <= sum_cur[21:0] * width_rd;
		if (ctl.mul_hi) p_q <= (PROD_W'(sum_cur[SUM_W-1:22] * width_rd) << 22) + PROD_W'(plo_q);
	end

	// interpolation between neighbor bands
	logic [CNT_W-1:0]        t2_q;
	logic signed [LVL_W-1:0] l2_q;
	logic [CNT_W-1:0]        d_q;
	logic signed [23:0]      m1_q;
	logic signed [24:0]      num_q;
	logic [24:0]             mag_q;
	logic                    neg_q;

	logic [BAND_W-1:0]       prev_t1;
	logic signed [LVL_W-1:0] prev_l1;
	logic [CNT_W-1:0]        up_span;
	logic [CNT_W-1:0]        dn_span;
	logic signed [23:0]      m2;
	logic [24:0]             num_abs;

	assign prev_t1 = prev_rd[BAND_W+LVL_W-1:LVL_W];
	assign prev_l1 = $signed(prev_rd[LVL_W-1:0]);
	assign up_span = t2_q - idx_q;
	assign dn_span = idx_q - CNT_W'(prev_t1);
	assign m2      = l2_q * $signed({1'b0, dn_span});
	assign num_abs = num_q[24] ? 25'(-num_q) : 25'(num_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0;
			t2_q <= '0;
		end else begin
			if (ctl.t1_clr) t1_q <= '0;
			else if (ctl.t1_upd) t1_q <= idx_a;
			if (ctl.t2_init) t2_q <= cnt;
			else if (ctl.t2_upd) t2_q <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.t1_upd) l1_q <= cur_level;
		if (ctl.t2_upd) l2_q <= cur_level;
		if (ctl.ip_m1) begin
			m1_q <= prev_l1 * $signed({1'b0, up_span});
			d_q  <= t2_q - CNT_W'(prev_t1);
		end
		if (ctl.ip_m2) num_q <= 25'(m1_q) + 25'(m2);
		if (ctl.ip_abs) begin
			neg_q <= num_q[24];
			mag_q <= num_abs + 25'(d_q >> 1);
		end
	end

	// shared units
	logic              div_done;
	logic [PROD_W-1:0] quo;
	logic              lvl_done;
	logic signed [LVL_W-1:0] lvl_res;
	logic [16:0]       ipq;
	logic signed [LVL_W-1:0] ip_val;

	obpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (ctl.div_sel ? PROD_W'(mag_q) : p_q),
		.den    (ctl.div_sel ? HITS_W'(d_q) : hits_cur),
		.done   (div_done),
		.quo    (quo)
	);

	obpa_lvl u_lvl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.lvl_start),
		.x      (ctl.lvl_fb ? quo : PROD_W'(pw_q)),
		.fb     (ctl.lvl_fb),
		.done   (lvl_done),
		.level  (lvl_res)
	);

	assign ipq    = quo[16:0];
	assign ip_val = neg_q ? $signed(LVL_W'(~ipq + 17'd1)) : $signed(LVL_W'(ipq));

	always_comb begin
		case (ctl.lvl_src)
			LS_RD:    cur_level = level_rd;
			LS_FLOOR: cur_level = floor_q;
			LS_LVL:   cur_level = lvl_res;
			LS_MIN:   cur_level = MIN_LEVEL;
			LS_IP:    cur_level = ip_val;
			default:  cur_level = MIN_LEVEL;
		endcase
	end

	// loudest band, scanned from the top band down
	logic [BAND_W-1:0]       loud_q;
	logic signed [LVL_W-1:0] maxl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loud_q <= '0;
			maxl_q <= MIN_LEVEL;
		end else if (ctl.t2_init) begin
			loud_q <= '0;
			maxl_q <= MIN_LEVEL;
		end else if (ctl.loud_upd && cur_level > MIN_LEVEL && cur_level >= maxl_q) begin
			loud_q <= idx_a;
			maxl_q <= cur_level;
		end
	end

	// result register
	logic      out_vld_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (ctl.out_load) out_vld_q <= 1'b1;
		else if (!out_stall) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q.band_out     <= idx_a;
			out_q.level        <= level_rd;
			out_q.peak_level   <= new_peak;
			out_q.loudest_band <= loud_q;
			out_q.last         <= idx_q == cnt - CNT_W'(1);
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		sts.ptr_lt_cnt  = ptr_q < cnt;
		sts.ptr_ge1     = ptr_q != '0;
		sts.bin_ge_edge = {1'b0, bin_q} >= edge_rd;
		sts.pw_zero     = pw_q == '0;
		sts.idx_lt_cnt  = idx_q < cnt;
		sts.idx_zero    = idx_q == '0;
		sts.hits_zero   = hits_cur == '0;
		sts.quo_zero    = quo == '0;
		sts.ip_none     = prev_t1 == '0 || t2_q == cnt;
		sts.div_done    = div_done;
		sts.lvl_done    = lvl_done;
		sts.out_busy    = out_vld_q && out_stall;
	end

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_wr |-> (ptr_q != '0 && ptr_q < cnt))
		else $error("accumulate outside collected bands");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(out_vld_q && out_stall))
		else $error("result overwritten before transfer");

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.lvl_wr |-> idx_q < cnt)
		else $error("level written beyond band count");

endmodule

`default_nettype wire

[design/obpa_ctrl.sv]
// ----------------------------------------------------------------------------
// obpa_ctrl
// Sequencer for bin accumulation and the end-of-frame band passes.
// ----------------------------------------------------------------------------
`default_nettype none

module obpa_ctrl import obpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] command,
	output logic       in_stall,
	input  sts_t       sts,
	output ctl_t       ctl
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.idx_op  = IX_HOLD;
		ctl.lvl_src = LS_RD;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.capture = 1'b1;
					case (command)
						CMD_LOAD: ctl.tbl_wr = 1'b1;
						CMD_BIN:  state_d = ST_ACC_RD;
						CMD_END: begin
							ctl.idx_op = IX_ZERO;
							ctl.t1_clr = 1'b1;
							state_d    = ST_B0;
						end
						default: ;
					endcase
				end
			end
			ST_ACC_RD: begin
				ctl.use_ptr = 1'b1;
				state_d     = ST_ACC_CHK;
			end
			ST_ACC_CHK: begin
				ctl.use_ptr = 1'b1;
				if (sts.ptr_lt_cnt && sts.bin_ge_edge) begin
					ctl.ptr_inc = 1'b1;
					state_d     = ST_ACC_RD;
				end else begin
					ctl.acc_wr = sts.ptr_ge1 && sts.ptr_lt_cnt;
					state_d    = ST_IDLE;
				end
			end
			ST_B0: begin
				if (sts.pw_zero) begin
					ctl.lvl_src = LS_FLOOR;
					ctl.lvl_wr  = 1'b1;
					ctl.idx_op  = IX_INC;
					state_d     = ST_P1_RD;
				end else begin
					ctl.lvl_start = 1'b1;
					state_d       = ST_B0_W;
				end
			end
			ST_B0_W: begin
				if (sts.lvl_done) begin
					ctl.lvl_src = LS_LVL;
					ctl.lvl_wr  = 1'b1;
					ctl.idx_op  = IX_INC;
					state_d     = ST_P1_RD;
				end
			end
			ST_P1_RD: begin
				if (sts.idx_lt_cnt) begin
					state_d = ST_P1_EVAL;
				end else begin
					ctl.idx_op = IX_TOP;
					state_d    = ST_P2_INIT;
				end
			end
			ST_P1_EVAL: begin
				if (sts.hits_zero) begin
					// remember the filled band below for the interpolation pass
					ctl.prev_wr = 1'b1;
					ctl.idx_op  = IX_INC;
					state_d     = ST_P1_RD;
				end else begin
					ctl.mul_lo = 1'b1;
					state_d    = ST_P1_MUL;
				end
			end
			ST_P1_MUL: begin
				ctl.mul_hi = 1'b1;
				state_d    = ST_P1_DIVS;
			end
			ST_P1_DIVS: begin
				ctl.div_start = 1'b1;
				state_d       = ST_P1_DIVW;
			end
			ST_P1_DIVW: begin
				if (sts.div_done) begin
					if (sts.quo_zero) begin
						ctl.lvl_src = LS_FLOOR;
						ctl.lvl_wr  = 1'b1;
						ctl.t1_upd  = 1'b1;
						ctl.idx_op  = IX_INC;
						state_d     = ST_P1_RD;
					end else begin
						ctl.lvl_start = 1'b1;
						ctl.lvl_fb    = 1'b1;
						state_d       = ST_P1_LVLW;
					end
				end
			end
			ST_P1_LVLW: begin
				if (sts.lvl_done) begin
					ctl.lvl_src = LS_LVL;
					ctl.lvl_wr  = 1'b1;
					ctl.t1_upd  = 1'b1;
					ctl.idx_op  = IX_INC;
					state_d     = ST_P1_RD;
				end
			end
			ST_P2_INIT: begin
				ctl.t2_init = 1'b1;
				state_d     = ST_P2_RD;
			end
			ST_P2_RD: begin
				if (sts.idx_zero) state_d = ST_OUT_RD;
				else state_d = ST_P2_EVAL;
			end
			ST_P2_EVAL: begin
				if (!sts.hits_zero) begin
					ctl.lvl_src  = LS_RD;
					ctl.t2_upd   = 1'b1;
					ctl.loud_upd = 1'b1;
					ctl.idx_op   = IX_DEC;
					state_d      = ST_P2_RD;
				end else if (sts.ip_none) begin
					ctl.lvl_src = LS_MIN;
					ctl.lvl_wr  = 1'b1;
					ctl.idx_op  = IX_DEC;
					state_d     = ST_P2_RD;
				end else begin
					ctl.ip_m1 = 1'b1;
					state_d   = ST_P2_M2;
				end
			end
			ST_P2_M2: begin
				ctl.ip_m2 = 1'b1;
				state_d   = ST_P2_ABS;
			end
			ST_P2_ABS: begin
				ctl.ip_abs = 1'b1;
				state_d    = ST_P2_DIVS;
			end
			ST_P2_DIVS: begin
				ctl.div_start = 1'b1;
				ctl.div_sel   = 1'b1;
				state_d       = ST_P2_DIVW;
			end
			ST_P2_DIVW: begin
				if (sts.div_done) begin
					ctl.lvl_src  = LS_IP;
					ctl.lvl_wr   = 1'b1;
					ctl.loud_upd = 1'b1;
					ctl.idx_op   = IX_DEC;
					state_d      = ST_P2_RD;
				end
			end
			ST_OUT_RD: begin
				if (sts.idx_lt_cnt) begin
					state_d = ST_OUT_EVAL;
				end else begin
					ctl.frame_clr = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_OUT_EVAL: begin
				// hold while the previous result waits for transfer
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					ctl.idx_op   = IX_INC;
					state_d      = ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[design/octave_band_power_aggregator_top.sv]
// ----------------------------------------------------------------------------
// octave_band_power_aggregator_top
// Fractional-octave band power aggregator with peak hold and loudest band.
// ----------------------------------------------------------------------------
// Table loads and commands with no effect are done without leaving idle. A
// spectrum bin moves the band pointer past each band edge that it reaches,
// each step reading the edge memory through its registered port. End of
// frame runs three passes over the bands in use: filled bands use the
// divider and a log unit with a one-bit-per-cycle leading-one search,
// interpolated empty bands use the same divider, and results then leave one
// at a time while the output is not stalled. Results of a frame come out in
// band order, band 0 first.
`default_nettype none

module octave_band_power_aggregator_top import obpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	ctl_t ctl;
	sts_t sts;

	obpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (in_data.command),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	obpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

`default_nettype wire
